[src/ttcw_pkg.sv]
// Shared types and constants of the text terminal cursor writer.
`default_nettype none

package ttcw_pkg;

    // Widths of the character and the result fields.
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 8;
    localparam int ADDR_W    = 11;
    localparam int ENTRY_W   = 16;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 7;

    // Tab stops fall on multiples of this value (a power of two).
    localparam int TAB_STOP   = 8;
    localparam int TAB_SHIFT  = 3;

    // Attribute byte after reset: light grey on black.
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

    // Character codes that the cursor logic obeys.
    localparam logic [CH_W-1:0] CODE_BACKSPACE       = 8'h08;
    localparam logic [CH_W-1:0] CODE_TAB             = 8'h09;
    localparam logic [CH_W-1:0] CODE_NEWLINE         = 8'h0A;
    localparam logic [CH_W-1:0] CODE_RETURN          = 8'h0D;
    localparam logic [CH_W-1:0] CODE_FIRST_PRINTABLE = 8'h20;

    // One result transaction.
    typedef struct packed {
        logic                 write_cell;
        logic [ADDR_W-1:0]    cell_address;
        logic [ENTRY_W-1:0]   cell_entry;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_col;
    } result_t;

endpackage

`default_nettype wire

[src/text_terminal_cursor_writer_unit.sv]
// Top level of the text terminal cursor writer: cursor tracking and cell writes.
`default_nettype none

// Takes one character per transaction and keeps a cursor on a ROWS x COLUMNS text
// screen. Backspace, tab, carriage return and newline move the cursor; any code of
// 0x20 or above yields a cell write at row*COLUMNS+column with the character in the
// low byte and the attribute register in the high byte, then advances the cursor,
// wrapping at the line end and from the last row to row 0. Every character yields
// one result that reports the cursor afterwards. The block accepts one character
// per clock cycle unless a held result waits for m_ready; the cursor register,
// updated once per character by a single pass of compare and add logic, sets
// that rate. The input register holds an accepted character, then the result
// register presents its result. The user must write the attribute register through
// cfg_wr_en/cfg_wr_data only while the block is idle; this is not enforced.
module text_terminal_cursor_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Attribute register write port.
    input  wire logic                               cfg_wr_en,
    input  wire logic [ttcw_pkg::COLOR_W-1:0]       cfg_wr_data,
    // Character input channel.
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [ttcw_pkg::CH_W-1:0]          s_ch,
    // Result channel.
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_write_cell,
    output logic [ttcw_pkg::ADDR_W-1:0]             m_cell_address,
    output logic [ttcw_pkg::ENTRY_W-1:0]            m_cell_entry,
    output logic [ttcw_pkg::OUT_ROW_W-1:0]          m_cursor_row,
    output logic [ttcw_pkg::OUT_COL_W-1:0]          m_cursor_col
);

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COLX_W = COL_W + 1;
    localparam int PROD_W = ROW_W + 10;

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COLX_W-1:0] COL_LIMIT = COLX_W'(COLUMNS);

    logic [ttcw_pkg::COLOR_W-1:0] color_reg;
    logic                         in_valid_reg;
    logic [ttcw_pkg::CH_W-1:0]    ch_reg;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic                         out_valid_reg;
    ttcw_pkg::result_t            result_reg, result_next;

    logic              advance;
    logic              process;
    logic [ROW_W-1:0]  row_inc;
    logic [COLX_W-1:0] col_ext;
    logic [COLX_W-1:0] col_inc;
    logic [COLX_W-1:0] tab_sum;
    logic [COLX_W-1:0] tab_next;
    logic [PROD_W-1:0] cell_addr_full;

    // Handshake: the result register frees up when empty or when taken.
    assign advance = !out_valid_reg || m_ready;
    assign process = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Attribute register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= ttcw_pkg::COLOR_RESET;
        end else if (cfg_wr_en) begin
            color_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg <= s_ch;
        end
    end

    // Candidate cursor positions.
    assign row_inc        = (row_reg == LAST_ROW) ? '0 : row_reg + ROW_W'(1);
    assign col_ext        = COLX_W'(col_reg);
    assign col_inc        = col_ext + COLX_W'(1);
    assign tab_sum        = col_ext + COLX_W'(ttcw_pkg::TAB_STOP);
    assign tab_next       = {tab_sum[COLX_W-1:ttcw_pkg::TAB_SHIFT],
                             ttcw_pkg::TAB_SHIFT'(0)};
    assign cell_addr_full = PROD_W'(row_reg) * PROD_W'(COLUMNS) + PROD_W'(col_reg);

    // Decode the character and work out the new cursor and the cell write.
    always_comb begin
        row_next                 = row_reg;
        col_next                 = col_reg;
        result_next.write_cell   = 1'b0;
        result_next.cell_address = '0;
        result_next.cell_entry   = '0;
        case (ch_reg)
            ttcw_pkg::CODE_BACKSPACE: begin
                if (col_reg != '0) begin
                    col_next = col_reg - COL_W'(1);
                end
            end
            ttcw_pkg::CODE_TAB: begin
                if (tab_next >= COL_LIMIT) begin
                    col_next = '0;
                    row_next = row_inc;
                end else begin
                    col_next = tab_next[COL_W-1:0];
                end
            end
            ttcw_pkg::CODE_RETURN: begin
                col_next = '0;
            end
            ttcw_pkg::CODE_NEWLINE: begin
                col_next = '0;
                row_next = row_inc;
            end
            default: begin
                if (ch_reg >= ttcw_pkg::CODE_FIRST_PRINTABLE) begin
                    result_next.write_cell   = 1'b1;
                    result_next.cell_address = cell_addr_full[ttcw_pkg::ADDR_W-1:0];
                    result_next.cell_entry   = {color_reg, ch_reg};
                    if (col_inc >= COL_LIMIT) begin
                        col_next = '0;
                        row_next = row_inc;
                    end else begin
                        col_next = col_inc[COL_W-1:0];
                    end
                end
            end
        endcase
        result_next.cursor_row = ttcw_pkg::OUT_ROW_W'(row_next);
        result_next.cursor_col = ttcw_pkg::OUT_COL_W'(col_next);
    end

    // Cursor state, committed once per processed character.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (process) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            result_reg <= result_next;
        end
    end

    // Result channel outputs.
    assign m_valid        = out_valid_reg;
    assign m_write_cell   = result_reg.write_cell;
    assign m_cell_address = result_reg.cell_address;
    assign m_cell_entry   = result_reg.cell_entry;
    assign m_cursor_row   = result_reg.cursor_row;
    assign m_cursor_col   = result_reg.cursor_col;

endmodule

`default_nettype wire
